>>> design/ptp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_pkg: shared types and constants of the pausable tick prescaler
// Request codes, the sequencer states and the input and result beat layouts.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int unsigned TimeW  = 64;
  localparam int unsigned ResW   = 32;
  localparam int unsigned ReqW   = 3;
  localparam int unsigned PaddrW = 3;

  // request codes
  localparam logic [ReqW-1:0] REQ_FREEZE   = 3'd0;
  localparam logic [ReqW-1:0] REQ_UNFREEZE = 3'd1;
  localparam logic [ReqW-1:0] REQ_START    = 3'd2;
  localparam logic [ReqW-1:0] REQ_UPDATE   = 3'd3;
  localparam logic [ReqW-1:0] REQ_CLEAR    = 3'd4;

  // register index of tick_resolution
  localparam logic [PaddrW-3:0] REG_TICK_RES = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIME,
    ST_SPAN,
    ST_SUM,
    ST_DIV,
    ST_ACC,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [TimeW-1:0] now_ns;
  } in_beat_t;

  typedef struct packed {
    logic [TimeW-1:0] ticks_added;
    logic [TimeW-1:0] total_ticks;
    logic             is_running;
    logic             negative_span;
  } out_beat_t;

endpackage

>>> design/pausable_tick_prescaler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pausable_tick_prescaler_top: pausable prescaler timer
// Derives a pausable global time from sampled nanosecond stamps and counts
// whole ticks of a programmable resolution with a bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one request beat
//   carrying req_type and a sampled now_ns. Every request yields exactly one
//   result beat on the output channel (out_valid_o / out_ready_i / out_data_o).
//   The APB port holds tick_resolution at byte address 0; write it only while
//   the block is idle. A written zero reads back and acts as one.
// Timing:
//   Freeze, unfreeze, start, clear and unused codes pass through the time
//   and finish steps; an update also takes the span, sum, divide and
//   accumulate steps in between: the span goes through a restoring divider
//   that shifts one quotient bit per cycle over the 64-bit dividend. One
//   request is processed at a time; in_ready_o rises again once the result
//   has entered the output register, so a new request overlaps a waiting beat.
// Reset:
//   All timer state clears, tick_resolution returns to one, no beat is valid.
// Stall:
//   When the receiver holds out_ready_i low the result waits in the output
//   register; a following request is taken and then holds before its result.
// ----------------------------------------------------------------------------
module pausable_tick_prescaler_top
  import ptp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_beat_t               in_data_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_beat_t              out_data_o,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PaddrW-1:0]      paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned CntW = $clog2(TimeW);

  state_e state_q, state_d;

  // captured request
  logic [ReqW-1:0]  req_q;
  logic [TimeW-1:0] now_q;

  // timer state
  logic [ResW-1:0]  res_q;
  logic [TimeW-1:0] freeze_mark_q, freeze_mark_d;
  logic [TimeW-1:0] paused_total_q, paused_total_d;
  logic [TimeW-1:0] last_update_q, last_update_d;
  logic [ResW-1:0]  leftover_q, leftover_d;
  logic [TimeW-1:0] tick_count_q, tick_count_d;
  logic             running_q, running_d;

  // datapath: work holds global time, span, dividend, then quotient
  logic [TimeW-1:0] work_q, work_d;
  logic [ResW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             neg_q, neg_d;

  // output register
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_q, out_d;

  logic             frozen;
  logic             cfg_wr;
  logic [ResW:0]    div_cand;
  logic [ResW:0]    div_diff;
  logic             div_fit;

  assign frozen = (freeze_mark_q != '0);

  // ---------------- configuration port ----------------
  // Decode the word address only; the byte offset bits are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[PaddrW-1:2] == REG_TICK_RES);
  assign prdata = (paddr[PaddrW-1:2] == REG_TICK_RES) ? res_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= {{(ResW-1){1'b0}}, 1'b1};
    end else if (cfg_wr) begin
      // a zero resolution acts as one
      res_q <= (pwdata == '0) ? {{(ResW-1){1'b0}}, 1'b1} : pwdata;
    end
  end

  // ---------------- divider step ----------------
  // Shift the next dividend bit into the partial remainder and try the
  // resolution against it; the quotient bit enters work at the bottom.
  assign div_cand = {rem_q, work_q[TimeW-1]};
  assign div_diff = div_cand - {1'b0, res_q};
  assign div_fit  = (div_cand >= {1'b0, res_q});

  // ---------------- sequencer ----------------
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    work_d         = work_q;
    rem_d          = rem_q;
    cnt_d          = cnt_q;
    neg_d          = neg_q;
    freeze_mark_d  = freeze_mark_q;
    paused_total_d = paused_total_q;
    last_update_d  = last_update_q;
    leftover_d     = leftover_q;
    tick_count_d   = tick_count_q;
    running_d      = running_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_d          = out_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_TIME;
        end
      end
      ST_TIME: begin
        // unfreeze wants the paused span; everything else the global time
        if (req_q == REQ_UNFREEZE) begin
          work_d = now_q - freeze_mark_q;
        end else begin
          work_d = (frozen ? freeze_mark_q : now_q) - paused_total_q;
        end
        state_d = (req_q == REQ_UPDATE) ? ST_SPAN : ST_FINISH;
      end
      ST_SPAN: begin
        last_update_d = work_q;
        work_d        = work_q - last_update_q;
        neg_d         = work_d[TimeW-1];
        state_d       = ST_SUM;
      end
      ST_SUM: begin
        // wraps at 2^64 before the divide
        work_d  = work_q + {{(TimeW-ResW){1'b0}}, leftover_q};
        rem_d   = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d  = div_fit ? div_diff[ResW-1:0] : div_cand[ResW-1:0];
        work_d = {work_q[TimeW-2:0], div_fit};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CntW'(TimeW - 1)) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        tick_count_d = tick_count_q + work_q;
        leftover_d   = rem_q;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        // hold here while the previous result still waits
        if (!out_valid_q || out_ready_i) begin
          case (req_q)
            REQ_FREEZE: begin
              freeze_mark_d = (now_q == '0) ? {{(TimeW-1){1'b0}}, 1'b1} : now_q;
            end
            REQ_UNFREEZE: begin
              if (frozen) begin
                paused_total_d = paused_total_q + work_q;
                freeze_mark_d  = '0;
              end
            end
            REQ_START: begin
              last_update_d = work_q;
              running_d     = 1'b1;
            end
            REQ_CLEAR: begin
              last_update_d = '0;
              leftover_d    = '0;
              tick_count_d  = '0;
              running_d     = 1'b0;
            end
            default: begin
            end
          endcase
          out_valid_d         = 1'b1;
          out_d.ticks_added   = (req_q == REQ_UPDATE) ? work_q : '0;
          out_d.total_ticks   = tick_count_d;
          out_d.is_running    = running_d;
          out_d.negative_span = (req_q == REQ_UPDATE) && neg_q;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      freeze_mark_q  <= '0;
      paused_total_q <= '0;
      last_update_q  <= '0;
      leftover_q     <= '0;
      tick_count_q   <= '0;
      running_q      <= 1'b0;
      cnt_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      freeze_mark_q  <= freeze_mark_d;
      paused_total_q <= paused_total_d;
      last_update_q  <= last_update_d;
      leftover_q     <= leftover_d;
      tick_count_q   <= tick_count_d;
      running_q      <= running_d;
      cnt_q          <= cnt_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i.req_type;
      now_q <= in_data_i.now_ns;
    end
    work_q <= work_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // the resolution never reaches zero, so the divider always terminates sanely
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_q != '0)
    else $error("tick resolution is zero");

  // the partial remainder stays below the resolution through the divide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < res_q))
    else $error("divider remainder out of range");

  // the last divider step hands over to the accumulate step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == CntW'(TimeW - 1)) |=> (state_q == ST_ACC))
    else $error("divider did not finish after the full dividend");

  // a new result beat only appears from the finish step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result beat raised outside finish");

  // a result is never overwritten while it still waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(out_q))
    else $error("waiting result beat changed");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the pausable tick prescaler
// Drives request beats through a short directed table and then random
// sequences over several tick resolutions. A scoreboard predicts each result beat
// from its own timer state copy, or uses a typed result, and compares field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import ptp_pkg::*;

  // Request codes the block must pass over untouched
  localparam logic [ReqW-1:0]   REQ_SPARE_LO  = 3'd5;
  localparam logic [ReqW-1:0]   REQ_SPARE_MID = 3'd6;
  localparam logic [ReqW-1:0]   REQ_SPARE_HI  = 3'd7;
  localparam logic [PaddrW-1:0] RES_ADDR      = {REG_TICK_RES, 2'b00};
  localparam logic [TimeW-1:0]  ALL_ONES      = '1;

  localparam int unsigned IDLE_PCT    = 18;   // share of cycles either side idles
  localparam int unsigned PHASE_BEATS = 220;  // random request beats per resolution
  localparam int unsigned CALM_PHASE  = 3;    // phase run without any idling
  localparam int unsigned TAIL_CYCLES = 80;   // beyond the longest update latency
  localparam int unsigned STALL_LIMIT = 3000; // cycles without any beat moving
  localparam int unsigned PRINT_LIMIT = 40;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    in_beat_t    beat;
    bit          typed;    // result written out by hand below
    out_beat_t   res;
    logic [31:0] cfg_val;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_beat_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_beat_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pausable_tick_prescaler_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Timer state as the block should hold it
  logic [31:0]      res_q      = 32'd1;
  logic [TimeW-1:0] frz_mark   = '0;
  logic [TimeW-1:0] paused_sum = '0;
  logic [TimeW-1:0] last_gtime = '0;
  logic [31:0]      spare_ns   = '0;
  logic [TimeW-1:0] tick_acc   = '0;
  logic             run_flag   = 1'b0;

  out_beat_t   result_q[$];      // results owed by the block, oldest first
  stim_row_t   dir_rows[$];
  bit          typed_chk;        // set alongside each request beat
  out_beat_t   typed_res;
  int unsigned idle_pct = IDLE_PCT;
  int unsigned err_cnt  = 0;
  int unsigned quiet_cycles = 0;
  logic [TimeW-1:0] wall_ns = '0;  // running clock for well-formed sequences

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic logic [TimeW-1:0] global_ns(input logic [TimeW-1:0] now);
    return ((frz_mark != '0) ? frz_mark : now) - paused_sum;
  endfunction

  // Advance the expected timer state by one request and build its result
  task automatic step_timer(input in_beat_t b, output out_beat_t r);
    logic [TimeW-1:0] g, span, sum, added;
    logic             neg;
    added = '0;
    neg   = 1'b0;
    case (b.req_type)
      REQ_FREEZE: begin
        // zero marks "not frozen", so a freeze at time zero latches one
        frz_mark = (b.now_ns == '0) ? 64'd1 : b.now_ns;
      end
      REQ_UNFREEZE: begin
        if (frz_mark != '0) begin
          paused_sum = paused_sum + (b.now_ns - frz_mark);
          frz_mark   = '0;
        end
      end
      REQ_START: begin
        last_gtime = global_ns(b.now_ns);
        run_flag   = 1'b1;
      end
      REQ_UPDATE: begin
        // runs whether started or not; a backward span wraps and is flagged
        g          = global_ns(b.now_ns);
        span       = g - last_gtime;
        neg        = span[TimeW-1];
        last_gtime = g;
        sum        = {32'd0, spare_ns} + span;
        added      = sum / {32'd0, res_q};
        spare_ns   = 32'(sum % {32'd0, res_q});
        tick_acc   = tick_acc + added;
      end
      REQ_CLEAR: begin
        last_gtime = '0;
        spare_ns   = '0;
        tick_acc   = '0;
        run_flag   = 1'b0;
      end
      default: ;
    endcase
    r.ticks_added   = added;
    r.total_ticks   = tick_acc;
    r.is_running    = run_flag;
    r.negative_span = neg;
  endtask

  task automatic report_mismatch(input string what, input logic [TimeW-1:0] got,
                                 input logic [TimeW-1:0] want);
    err_cnt++;
    if (err_cnt <= PRINT_LIMIT)
      $display("[%0t] mismatch %s: got %h, want %h", $time, what, got, want);
  endtask

  // Scoreboard and watchdog, all on the rising edge
  always @(posedge clk_i) begin : scoreboard
    out_beat_t pred, want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      step_timer(in_data_i, pred);
      result_q.push_back(typed_chk ? typed_res : pred);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        report_mismatch("beat without request, total_ticks", out_data_o.total_ticks, '0);
      end else begin
        want = result_q.pop_front();
        if (out_data_o.ticks_added !== want.ticks_added)
          report_mismatch("ticks_added", out_data_o.ticks_added, want.ticks_added);
        if (out_data_o.total_ticks !== want.total_ticks)
          report_mismatch("total_ticks", out_data_o.total_ticks, want.total_ticks);
        if (out_data_o.is_running !== want.is_running)
          report_mismatch("is_running", 64'(out_data_o.is_running), 64'(want.is_running));
        if (out_data_o.negative_span !== want.negative_span)
          report_mismatch("negative_span", 64'(out_data_o.negative_span),
                          64'(want.negative_span));
      end
    end
    // Count cycles in which neither channel moves a beat
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("pausable_tick_prescaler_top regression: fail");
      $finish;
    end
  end

  // Receiver: stall at random, hold ready high through the calm phase
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= idle_pct);
  end

  // Offer one request beat; hold valid from the previous beat if no gap falls
  task automatic send_beat(input in_beat_t b, input bit chk, input out_beat_t res);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    typed_chk  = chk;
    typed_res  = res;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Drop valid and wait for every owed result, leaving the block idle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write tick_resolution over APB, then read it back
  task automatic write_res(input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RES_ADDR;
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    res_q = (v == '0) ? 32'd1 : v;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== res_q)
      report_mismatch("tick_resolution read-back", 64'(prdata), 64'(res_q));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_req(input logic [ReqW-1:0] req, input logic [TimeW-1:0] now);
    stim_row_t r;
    r.kind        = ROW_REQ;
    r.beat.req_type = req;
    r.beat.now_ns = now;
    r.typed       = 1'b0;
    r.res         = '0;
    r.cfg_val     = '0;
    dir_rows.push_back(r);
  endtask

  task automatic add_req_exp(input logic [ReqW-1:0] req, input logic [TimeW-1:0] now,
                             input logic [TimeW-1:0] ticks, input logic [TimeW-1:0] total,
                             input logic run, input logic neg);
    stim_row_t r;
    r.kind              = ROW_REQ;
    r.beat.req_type     = req;
    r.beat.now_ns       = now;
    r.typed             = 1'b1;
    r.res.ticks_added   = ticks;
    r.res.total_ticks   = total;
    r.res.is_running    = run;
    r.res.negative_span = neg;
    r.cfg_val           = '0;
    dir_rows.push_back(r);
  endtask

  task automatic add_cfg(input logic [31:0] v);
    stim_row_t r;
    r.kind    = ROW_CFG;
    r.beat    = '0;
    r.typed   = 1'b0;
    r.res     = '0;
    r.cfg_val = v;
    dir_rows.push_back(r);
  endtask

  // Random request: mostly a forward-running clock with sensible requests,
  // some backward steps, some pure noise
  task automatic pick_request(output in_beat_t b);
    int unsigned      sel;
    logic [TimeW-1:0] stride;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      b.req_type = ReqW'($urandom_range(REQ_FREEZE, REQ_SPARE_HI));
      b.now_ns   = {$urandom, $urandom};
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 65)
        stride = 64'($urandom_range(0, 3000));
      else if (sel < 85)
        stride = 64'($urandom);
      else if (sel < 93)
        stride = {$urandom, $urandom} >> $urandom_range(0, 63);
      else
        stride = 64'd0 - 64'($urandom_range(1, 2000));
      wall_ns = wall_ns + stride;
      sel = $urandom_range(0, 99);
      if (sel < 50)
        b.req_type = REQ_UPDATE;
      else if (sel < 62)
        b.req_type = REQ_START;
      else if (sel < 75)
        b.req_type = REQ_FREEZE;
      else if (sel < 89)
        b.req_type = REQ_UNFREEZE;
      else if (sel < 95)
        b.req_type = REQ_CLEAR;
      else
        b.req_type = ReqW'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
      b.now_ns = wall_ns;
    end
  endtask

  initial begin : stimulus
    in_beat_t    b;
    logic [31:0] res_plan[$];
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    typed_chk   = 1'b0;
    typed_res   = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, resolution one from reset
    add_req_exp(REQ_UPDATE, 64'd0, 64'd0, 64'd0, 1'b0, 1'b0);   // update before start
    add_req_exp(REQ_START, 64'd100, 64'd0, 64'd0, 1'b1, 1'b0);
    add_req_exp(REQ_UPDATE, 64'd150, 64'd50, 64'd50, 1'b1, 1'b0);
    add_req(REQ_UPDATE, 64'd140);                               // time runs backward
    add_req(REQ_FREEZE, 64'd0);                                 // freeze at time zero
    add_req(REQ_UPDATE, 64'd999);                               // frozen update
    add_req(REQ_FREEZE, 64'd500);                               // freeze again
    add_req(REQ_UNFREEZE, 64'd800);
    add_req(REQ_UNFREEZE, 64'd900);                             // not frozen: no effect
    add_req(REQ_UPDATE, 64'd1000);
    add_req_exp(REQ_CLEAR, ALL_ONES, 64'd0, 64'd0, 1'b0, 1'b0);
    add_req(REQ_UPDATE, ALL_ONES);
    add_req(REQ_SPARE_LO, ALL_ONES);
    add_req(REQ_SPARE_MID, 64'd0);
    add_req(REQ_SPARE_HI, 64'h5555_5555_5555_5555);
    add_req(REQ_START, 64'd0);
    add_req(REQ_FREEZE, ALL_ONES);
    add_req(REQ_UPDATE, 64'd0);
    add_req(REQ_UNFREEZE, 64'd0);                               // paused span wraps
    add_req(REQ_UPDATE, 64'h8000_0000_0000_0000);
    // widest resolution: carry a remainder, then let remainder plus span wrap
    add_cfg(32'hFFFF_FFFF);
    add_req_exp(REQ_CLEAR, 64'd0, 64'd0, 64'd0, 1'b0, 1'b0);
    add_req(REQ_START, 64'd1000);
    add_req(REQ_UPDATE, 64'd1000 + 64'h1234);
    add_req(REQ_UPDATE, 64'd1000 + 64'h1233);
    // a written zero acts as one
    add_cfg(32'd0);
    add_req(REQ_UPDATE, 64'hAAAA_AAAA_AAAA_AAAA);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        settle();
        write_res(dir_rows[k].cfg_val);
      end else begin
        send_beat(dir_rows[k].beat, dir_rows[k].typed, dir_rows[k].res);
      end
    end

    // Random part, one phase per resolution; extremes included
    res_plan = '{32'd1, 32'd7, 32'hFFFF_FFFF, 32'd1000, 32'd0, $urandom, 32'd2};
    foreach (res_plan[ph]) begin
      settle();
      write_res(res_plan[ph]);
      idle_pct = (ph == CALM_PHASE) ? 0 : IDLE_PCT;
      repeat (PHASE_BEATS) begin
        pick_request(b);
        send_beat(b, 1'b0, '0);
      end
    end

    // Drain, then give stray beats a chance to show up
    idle_pct = IDLE_PCT;
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("pausable_tick_prescaler_top regression: pass");
    end else begin
      $display("pausable_tick_prescaler_top regression: fail");
    end
    $finish;
  end

endmodule
